[rtl/core/vbsb_pkg.sv]
// ----------------------------------------------------------------------------
// vbsb_pkg
// Shared types, constants and value mapping functions for the varint byte
// stream buffer: buffer geometry, request and status codes, zigzag and float
// sign folding, width masking and group count.
// ----------------------------------------------------------------------------
package vbsb_pkg;

    // buffer geometry
    localparam int BUFFER_BYTES = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int POS_W        = ADDR_W + 1;

    // request codes
    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // value kinds
    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;
    localparam logic [1:0] KIND_FLOAT    = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // group constants
    localparam logic [7:0]  GROUP_MASK = 8'h7F;
    localparam logic [7:0]  CONT_BIT   = 8'h80;
    localparam logic [31:0] FLIP_MASK  = 32'h7FFF_FFFF;
    localparam int          SIGN_BIT   = 31;
    localparam logic [2:0]  MAX_GROUPS = 3'd5;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // keep the low w bits; 32 or more keeps everything
    function automatic logic [31:0] width_mask(input logic [31:0] v, input logic [5:0] w);
        logic [31:0] m;
        begin
            if (w >= 6'd32)
                m = '1;
            else
                m = (32'd1 << w) - 32'd1;
            width_mask = v & m;
        end
    endfunction

    // zigzag fold: sign moves into bit 0
    function automatic logic [31:0] fold_sign(input logic [31:0] v);
        fold_sign = {v[30:0], 1'b0} ^ {32{v[SIGN_BIT]}};
    endfunction

    // zigzag unfold
    function automatic logic [31:0] unfold_sign(input logic [31:0] u);
        unfold_sign = u[0] ? ~{1'b0, u[31:1]} : {1'b0, u[31:1]};
    endfunction

    // sign-magnitude to ordered form for negative float patterns
    function automatic logic [31:0] float_flip(input logic [31:0] v);
        float_flip = v[SIGN_BIT] ? (v ^ FLIP_MASK) : v;
    endfunction

    // number of 7-bit groups needed for a value
    function automatic logic [2:0] group_count(input logic [31:0] d);
        group_count = 3'd1 + 3'(|d[31:7]) + 3'(|d[31:14]) + 3'(|d[31:21])
                    + 3'(|d[31:28]);
    endfunction

endpackage

[rtl/core/vbsb_mem.sv]
// ----------------------------------------------------------------------------
// vbsb_mem
// Byte store of the varint buffer: one write port and one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module vbsb_mem (
    input  logic            clk,
    input  logic            we,
    input  vbsb_pkg::addr_t waddr,
    input  logic [7:0]      wdata,
    input  vbsb_pkg::addr_t raddr,
    output logic [7:0]      rdata
);
    import vbsb_pkg::*;

    logic [7:0] mem [BUFFER_BYTES];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/varint_byte_stream_buffer_core.sv]
// ----------------------------------------------------------------------------
// varint_byte_stream_buffer_core
// Append-only byte buffer of 7-bit-group variable-length integers with
// optional zigzag sign fold and float sign flip.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted when start is high and busy is low; req_type,
//   kind, width and value are sampled at that edge. busy stays high until the
//   result is presented.
//   The result (read_value, status, byte_count) is valid for exactly one cycle
//   with done high; there is no back-pressure, the receiver must take it.
//   Steps from accept to done, with n bytes moved (1..5):
//     put:           one byte written per cycle through the store write
//                    port (overflow: nothing written)
//     get:           one byte per cycle from the registered store read
//                    port, then the ST_DEC state undoes the mapping
//                    (empty buffer or truncated group: nothing consumed)
//   A new transaction may start in the cycle done is high. The group shifter
//   and the store port used by each direction set the rate of one byte per cycle.
//   Reset clears both positions and the control state; the byte store is not
//   cleared, only bytes below the write position are ever used.
// ----------------------------------------------------------------------------
module varint_byte_stream_buffer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [1:0]  kind,
    input  logic [5:0]  width,
    input  logic [31:0] value,
    output logic        done,
    output logic [31:0] read_value,
    output logic [1:0]  status,
    output logic [2:0]  byte_count
);
    import vbsb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PUT  = 4'b0010,
        ST_GET  = 4'b0100,
        ST_DEC  = 4'b1000
    } state_t;

    state_t      state_reg;
    pos_t        write_pos_reg;
    pos_t        read_pos_reg;
    pos_t        pos_reg;
    logic [31:0] data_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  left_reg;
    logic [1:0]  kind_reg;
    logic [5:0]  width_reg;
    logic        done_reg;
    logic [31:0] read_value_reg;
    logic [1:0]  status_reg;
    logic [2:0]  byte_count_reg;

    logic        accept;
    logic [31:0] put_data;
    logic [2:0]  put_groups;
    pos_t        room;
    pos_t        pos_plus;
    logic [7:0]  rd_byte;
    logic [5:0]  shamt;
    logic [38:0] grp_shifted;
    logic [31:0] acc_new;
    logic [2:0]  cnt_new;
    logic [31:0] dec_value;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    addr_t       mem_raddr;

    assign accept = start && (state_reg == ST_IDLE);

    // put mapping and space check
    always_comb
    begin
        case (kind)
            KIND_SIGNED: put_data = width_mask(fold_sign(value), width);
            KIND_FLOAT:  put_data = fold_sign(float_flip(value));
            default:     put_data = width_mask(value, width);
        endcase
        put_groups = group_count(put_data);
        room       = pos_t'(BUFFER_BYTES) - write_pos_reg;
    end

    // group accumulate: place 7 bits at 7 * count
    always_comb
    begin
        pos_plus    = pos_reg + pos_t'(1);
        shamt       = 6'({cnt_reg, 3'b000}) - 6'(cnt_reg);
        grp_shifted = {32'b0, rd_byte[6:0]} << shamt;
        acc_new     = data_reg | grp_shifted[31:0];
        cnt_new     = cnt_reg + 3'd1;
    end

    // get mapping undo
    always_comb
    begin
        case (kind_reg)
            KIND_SIGNED: dec_value = unfold_sign(width_mask(data_reg, width_reg));
            KIND_FLOAT:  dec_value = float_flip(unfold_sign(data_reg));
            default:     dec_value = width_mask(data_reg, width_reg);
        endcase
    end

    // store port control
    always_comb
    begin
        mem_we    = (state_reg == ST_PUT);
        mem_wdata = (data_reg[7:0] & GROUP_MASK) | ((left_reg > 3'd1) ? CONT_BIT : 8'h00);
        if (state_reg == ST_IDLE)
            mem_raddr = read_pos_reg[ADDR_W-1:0];
        else
            mem_raddr = pos_plus[ADDR_W-1:0];
    end

    vbsb_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (write_pos_reg[ADDR_W-1:0]),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_byte)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= kind;
                        width_reg <= width;
                        pos_reg   <= read_pos_reg;
                        if (req_type == REQ_PUT)
                        begin
                            if (room < pos_t'(put_groups))
                            begin
                                done_reg       <= 1'b1;
                                read_value_reg <= '0;
                                status_reg     <= STATUS_OVERFLOW;
                                byte_count_reg <= '0;
                            end
                            else
                            begin
                                data_reg  <= put_data;
                                left_reg  <= put_groups;
                                cnt_reg   <= put_groups;
                                state_reg <= ST_PUT;
                            end
                        end
                        else
                        begin
                            if (read_pos_reg >= write_pos_reg)
                            begin
                                done_reg       <= 1'b1;
                                read_value_reg <= '0;
                                status_reg     <= STATUS_UNDERFLOW;
                                byte_count_reg <= '0;
                            end
                            else
                            begin
                                data_reg  <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_GET;
                            end
                        end
                    end
                end
                ST_PUT:
                begin
                    // one group per cycle, shifter moves the next group down
                    write_pos_reg <= write_pos_reg + pos_t'(1);
                    data_reg      <= {7'b0, data_reg[31:7]};
                    left_reg      <= left_reg - 3'd1;
                    if (left_reg == 3'd1)
                    begin
                        done_reg       <= 1'b1;
                        read_value_reg <= '0;
                        status_reg     <= STATUS_OK;
                        byte_count_reg <= cnt_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_GET:
                begin
                    if (!rd_byte[7] || (cnt_new == MAX_GROUPS))
                    begin
                        data_reg     <= acc_new;
                        cnt_reg      <= cnt_new;
                        read_pos_reg <= pos_plus;
                        state_reg    <= ST_DEC;
                    end
                    else if (pos_plus >= write_pos_reg)
                    begin
                        // truncated group: nothing consumed
                        done_reg       <= 1'b1;
                        read_value_reg <= '0;
                        status_reg     <= STATUS_UNDERFLOW;
                        byte_count_reg <= '0;
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        data_reg <= acc_new;
                        cnt_reg  <= cnt_new;
                        pos_reg  <= pos_plus;
                    end
                end
                ST_DEC:
                begin
                    done_reg       <= 1'b1;
                    read_value_reg <= dec_value;
                    status_reg     <= STATUS_OK;
                    byte_count_reg <= cnt_reg;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // outputs
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign byte_count = byte_count_reg;

endmodule
